/* rtl/gcr_track_anomaly_scanner_assert.svh */
// assertion macros shared by the scanner checker
`ifndef GCR_TRACK_ANOMALY_SCANNER_ASSERT_SVH
`define GCR_TRACK_ANOMALY_SCANNER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define GCR_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define GCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/gcr_scan_pkg.sv */
// shared types and constants for the gcr track anomaly scanner
`default_nettype none
package gcr_scan_pkg;

	localparam int unsigned MAX_HALF_TRACKS = 84;

	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_RUN_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_RUN_MIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_SYNC_LIMIT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KILLER_MIN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TRACK_MARGIN = 3'd4;

	// register reset values
	localparam logic [3:0]  SYNC_RUN_MIN_RST      = 4'd5;
	localparam logic [3:0]  LONG_RUN_MIN_RST      = 4'd10;
	localparam logic [2:0]  LONG_SYNC_LIMIT_RST   = 3'd5;
	localparam logic [15:0] KILLER_MIN_LENGTH_RST = 16'd100;
	localparam logic [11:0] LONG_TRACK_MARGIN_RST = 12'd200;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;

	// per-track sync status after the current beat
	typedef struct packed {
		logic       sync_seen;
		logic [2:0] long_cnt;
	} trk_stat_t;

	// per-track flags handed to the disk totals
	typedef struct packed {
		logic half;
		logic sync;
		logic dens;
	} trk_flags_t;

endpackage
`default_nettype wire

/* rtl/gcr_scan_track.sv */
// per-track 0xff run tracking and sync counters
`default_nettype none
module gcr_scan_track import gcr_scan_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire logic      upd,
	input  wire logic      is_ff,
	input  wire logic      last,
	input  wire logic [3:0] sync_run_min,
	input  wire logic [3:0] long_run_min,
	output trk_stat_t      stat
);

	logic [3:0] run_q, run_n;
	logic       sync_q;
	logic [2:0] long_q;

	always_comb begin
		run_n = run_q;
		stat.sync_seen = sync_q;
		stat.long_cnt = long_q;
		if (upd) begin
			if (is_ff) begin
				run_n = (run_q == 4'hF) ? run_q : run_q + 4'd1;
				if (run_n >= sync_run_min) stat.sync_seen = 1'b1;
				if (run_n > long_run_min)
					stat.long_cnt = (long_q == 3'd7) ? long_q : long_q + 3'd1;
			end else begin
				run_n = 4'd0;
			end
		end
	end

	// track state clears after the last beat has been reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 4'd0;
			sync_q <= 1'b0;
			long_q <= 3'd0;
		end else if (fire) begin
			if (last) begin
				run_q  <= 4'd0;
				sync_q <= 1'b0;
				long_q <= 3'd0;
			end else begin
				run_q  <= run_n;
				sync_q <= stat.sync_seen;
				long_q <= stat.long_cnt;
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/gcr_scan_disk.sv */
// running disk totals and confidence
`default_nettype none
module gcr_scan_disk import gcr_scan_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic       disk_start,
	input  wire logic       last,
	input  trk_flags_t      flags,
	output logic [5:0]      half_total,
	output logic [6:0]      sync_total,
	output logic [6:0]      dens_total,
	output logic [6:0]      conf
);

	logic [5:0] half_q, half_b;
	logic [6:0] sync_q, sync_b;
	logic [6:0] dens_q, dens_b;

	always_comb begin
		half_b = disk_start ? 6'd0 : half_q;
		sync_b = disk_start ? 7'd0 : sync_q;
		dens_b = disk_start ? 7'd0 : dens_q;
		half_total = half_b;
		sync_total = sync_b;
		dens_total = dens_b;
		if (last && flags.half && half_b != 6'h3F) half_total = half_b + 6'd1;
		if (last && flags.sync && sync_b != 7'h7F) sync_total = sync_b + 7'd1;
		if (last && flags.dens && dens_b != 7'h7F) dens_total = dens_b + 7'd1;
		conf = 7'd60
			+ ((half_total != 6'd0) ? 7'd15 : 7'd0)
			+ ((sync_total != 7'd0) ? 7'd10 : 7'd0)
			+ ((dens_total != 7'd0) ? 7'd10 : 7'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 6'd0;
			sync_q <= 7'd0;
			dens_q <= 7'd0;
		end else if (fire) begin
			half_q <= half_total;
			sync_q <= sync_total;
			dens_q <= dens_total;
		end
	end

endmodule
`default_nettype wire

/* rtl/gcr_track_anomaly_scanner.sv */
// gcr track anomaly scanner
// throughput one input beat per cycle while in_stall is low; input register then result register
// a beat that is not the last of its track yields no result and never waits
// the last beat waits in the input register only while the result register is held
// arst_n clears valids, run state and disk totals and reloads the config defaults
`default_nettype none
module gcr_track_anomaly_scanner import gcr_scan_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 disk_start,
	input  wire logic [6:0]           track_index,
	input  wire logic                 track_present,
	input  wire logic                 byte_valid,
	input  wire logic [7:0]           data_byte,
	input  wire logic [15:0]          declared_length,
	input  wire logic [31:0]          speed_zone,
	input  wire logic                 track_last,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      is_half_track,
	output logic                      is_extra_track,
	output logic                      killer_track,
	output logic                      sync_anomaly,
	output logic                      long_track,
	output logic                      density_anomaly,
	output logic [5:0]                half_track_total,
	output logic [6:0]                sync_anomaly_total,
	output logic [6:0]                density_anomaly_total,
	output logic [6:0]                confidence
);

	// configuration registers
	logic [3:0]  sync_run_min_q;
	logic [3:0]  long_run_min_q;
	logic [2:0]  long_sync_limit_q;
	logic [15:0] killer_min_length_q;
	logic [11:0] long_track_margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_run_min_q      <= SYNC_RUN_MIN_RST;
			long_run_min_q      <= LONG_RUN_MIN_RST;
			long_sync_limit_q   <= LONG_SYNC_LIMIT_RST;
			killer_min_length_q <= KILLER_MIN_LENGTH_RST;
			long_track_margin_q <= LONG_TRACK_MARGIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_RUN_MIN:      sync_run_min_q      <= cfg_data[3:0];
				REG_LONG_RUN_MIN:      long_run_min_q      <= cfg_data[3:0];
				REG_LONG_SYNC_LIMIT:   long_sync_limit_q   <= cfg_data[2:0];
				REG_KILLER_MIN_LENGTH: killer_min_length_q <= cfg_data[15:0];
				REG_LONG_TRACK_MARGIN: long_track_margin_q <= cfg_data[11:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// input register stage
	logic        v_s1;
	logic        disk_start_s1;
	logic [6:0]  idx_s1;
	logic        present_s1;
	logic        bvalid_s1;
	logic [7:0]  byte_s1;
	logic [15:0] dlen_s1;
	logic [31:0] speed_s1;
	logic        last_s1;

	logic advance;  // stage 1 beat leaves this cycle (or stage is empty)
	logic fire;     // stage 1 holds a beat that is processed this cycle

	// a non-last beat never needs the result register
	assign advance  = !v_s1 || !last_s1 || !out_valid || !out_stall;
	assign fire     = v_s1 && advance;
	assign in_stall = v_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			disk_start_s1 <= disk_start;
			idx_s1        <= track_index;
			present_s1    <= track_present;
			bvalid_s1     <= byte_valid;
			byte_s1       <= data_byte;
			dlen_s1       <= declared_length;
			speed_s1      <= speed_zone;
			last_s1       <= track_last;
		end
	end

	// track qualification
	logic       in_range;
	logic       pres;
	logic [5:0] trk;

	assign in_range = {1'b0, idx_s1} < 8'(MAX_HALF_TRACKS);
	assign pres     = in_range && present_s1;
	assign trk      = idx_s1[6:1];

	// run and sync counting for the current half-track
	trk_stat_t stat;

	gcr_scan_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.upd          (pres && bvalid_s1),
		.is_ff        (byte_s1 == SYNC_BYTE),
		.last         (last_s1),
		.sync_run_min (sync_run_min_q),
		.long_run_min (long_run_min_q),
		.stat         (stat)
	);

	// nominal track length per speed zone
	logic [12:0] zone_nom;
	logic [16:0] long_lim;

	always_comb begin
		priority if (trk < 6'd18) begin
			zone_nom = 13'd7692;
		end else if (trk < 6'd25) begin
			zone_nom = 13'd7142;
		end else if (trk < 6'd31) begin
			zone_nom = 13'd6666;
		end else begin
			zone_nom = 13'd6250;
		end
	end

	assign long_lim = 17'(zone_nom) + 17'(long_track_margin_q);

	// per-track flags
	logic       f_half, f_extra, f_killer, f_sync, f_long, f_dens;
	trk_flags_t flags;

	assign f_half   = pres && idx_s1[0];
	assign f_extra  = pres && (trk >= 6'd36);
	assign f_killer = pres && !stat.sync_seen && (dlen_s1 > killer_min_length_q);
	assign f_sync   = pres && (stat.long_cnt > long_sync_limit_q);
	assign f_long   = pres && ({1'b0, dlen_s1} > long_lim);
	assign f_dens   = in_range && (speed_s1[31:2] != 30'd0);

	assign flags.half = f_half;
	assign flags.sync = f_sync;
	assign flags.dens = f_dens;

	// disk totals, cleared on a disk start beat
	logic [5:0] half_tot;
	logic [6:0] sync_tot;
	logic [6:0] dens_tot;
	logic [6:0] conf;

	gcr_scan_disk u_disk (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.disk_start (disk_start_s1),
		.last       (last_s1),
		.flags      (flags),
		.half_total (half_tot),
		.sync_total (sync_tot),
		.dens_total (dens_tot),
		.conf       (conf)
	);

	// result register
	logic res_load;

	assign res_load = fire && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			is_half_track         <= f_half;
			is_extra_track        <= f_extra;
			killer_track          <= f_killer;
			sync_anomaly          <= f_sync;
			long_track            <= f_long;
			density_anomaly       <= f_dens;
			half_track_total      <= half_tot;
			sync_anomaly_total    <= sync_tot;
			density_anomaly_total <= dens_tot;
			confidence            <= conf;
		end
	end

endmodule
`default_nettype wire

/* rtl/gcr_scan_chk.sv */
// port-level checker for the gcr track anomaly scanner, bound to the top level
`default_nettype none
`include "gcr_track_anomaly_scanner_assert.svh"
module gcr_scan_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       is_half_track,
	input wire logic       sync_anomaly,
	input wire logic       density_anomaly,
	input wire logic [5:0] half_track_total,
	input wire logic [6:0] sync_anomaly_total,
	input wire logic [6:0] density_anomaly_total,
	input wire logic [6:0] confidence
);

	logic [6:0] conf_exp;

	assign conf_exp = 7'd60
		+ ((half_track_total != 6'd0) ? 7'd15 : 7'd0)
		+ ((sync_anomaly_total != 7'd0) ? 7'd10 : 7'd0)
		+ ((density_anomaly_total != 7'd0) ? 7'd10 : 7'd0);

	// a held result beat stays up
	`GCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result beat dropped while stalled")

	// confidence follows the reported totals
	`GCR_ASSERT_IMPLY(a_conf, clk, arst_n, out_valid, confidence == conf_exp, "confidence does not match totals")

	// a flagged track is always counted in its total
	`GCR_ASSERT_IMPLY(a_half_cnt, clk, arst_n, out_valid && is_half_track, half_track_total != 6'd0, "half track not counted")

	`GCR_ASSERT_IMPLY(a_anom_cnt, clk, arst_n, out_valid && (sync_anomaly || density_anomaly), (!sync_anomaly || sync_anomaly_total != 7'd0) && (!density_anomaly || density_anomaly_total != 7'd0), "anomaly not counted")

endmodule

bind gcr_track_anomaly_scanner gcr_scan_chk u_gcr_scan_chk (.*);
`default_nettype wire

/* test/tb.sv */
// self-checking testbench for the gcr track anomaly scanner
`timescale 1ns / 100ps

module tb import gcr_scan_pkg::*; ();

	// one input beat of a half-track, in port order
	typedef struct packed {
		logic        disk_start;
		logic [6:0]  idx;
		logic        present;
		logic        bvalid;
		logic [7:0]  dbyte;
		logic [15:0] dlen;
		logic [31:0] speed;
		logic        last;
	} track_beat_t;

	// one track report as it leaves the block
	typedef struct packed {
		logic       half_trk;
		logic       extra_trk;
		logic       killer;
		logic       sync_anom;
		logic       long_trk;
		logic       dens_anom;
		logic [5:0] half_total;
		logic [6:0] sync_total;
		logic [6:0] dens_total;
		logic [6:0] conf;
	} scan_res_t;

	// register file image, at register widths
	typedef struct packed {
		logic [3:0]  sync_min;
		logic [3:0]  long_min;
		logic [2:0]  long_limit;
		logic [15:0] killer_len;
		logic [11:0] margin;
	} scan_cfg_t;

	// directed row: beat, plus a report typed in by hand where it is obvious
	typedef struct packed {
		track_beat_t beat;
		logic        typed;
		scan_res_t   rep;
	} dir_row_t;

	localparam scan_cfg_t CFG_RST = {SYNC_RUN_MIN_RST, LONG_RUN_MIN_RST,
		LONG_SYNC_LIMIT_RST, KILLER_MIN_LENGTH_RST, LONG_TRACK_MARGIN_RST};
	localparam scan_cfg_t CFG_LOW  = {4'd1, 4'd1, 3'd0, 16'd0, 12'd0};
	localparam scan_cfg_t CFG_HIGH = {4'd15, 4'd15, 3'd7, 16'hFFFF, 12'hFFF};

	localparam int HOLD_CYCLES = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic                 disk_start;
	logic [6:0]           track_index;
	logic                 track_present;
	logic                 byte_valid;
	logic [7:0]           data_byte;
	logic [15:0]          declared_length;
	logic [31:0]          speed_zone;
	logic                 track_last;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 is_half_track;
	logic                 is_extra_track;
	logic                 killer_track;
	logic                 sync_anomaly;
	logic                 long_track;
	logic                 density_anomaly;
	logic [5:0]           half_track_total;
	logic [6:0]           sync_anomaly_total;
	logic [6:0]           density_anomaly_total;
	logic [6:0]           confidence;

	gcr_track_anomaly_scanner uut (.*);

	// predictor state: per-track run tracking and disk totals
	scan_cfg_t  cfg_now = CFG_RST;
	logic [3:0] run_len = '0;
	logic       sync_hit = 1'b0;
	logic [2:0] long_cnt = '0;
	logic [5:0] half_tot = '0;
	logic [6:0] sync_tot = '0;
	logic [6:0] dens_tot = '0;

	// reports still owed by the block, oldest first
	scan_res_t report_q[$];
	int        err_cnt = 0;

	// idling control, owned by the stimulus process
	int unsigned send_idle_pct = 16;
	int unsigned recv_idle_pct = 45;
	logic        hold_tgl = 1'b0;
	logic        hold_seen = 1'b0;
	int          hold_left = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#400000;
		$display("tb failed");
		$finish;
	end

	// nominal track length of the speed zone for this half-track
	function automatic int unsigned zone_len(input logic [6:0] idx);
		logic [5:0] trk;
		trk = idx[6:1];
		if (trk < 18) return 7692;
		if (trk < 25) return 7142;
		if (trk < 31) return 6666;
		return 6250;
	endfunction

	// advance the scanner model by one beat; report only on the last beat of a track
	task automatic scan_beat(input track_beat_t b, output bit has_rep, output scan_res_t r);
		bit in_rng;
		bit pres;
		in_rng = b.idx < MAX_HALF_TRACKS;
		pres = in_rng && b.present;
		has_rep = b.last;
		r = '0;
		// disk start clears the totals before this beat counts
		if (b.disk_start) begin
			half_tot = '0;
			sync_tot = '0;
			dens_tot = '0;
		end
		// sync run tracking, bytes of absent or out-of-range tracks ignored
		if (pres && b.bvalid) begin
			if (b.dbyte == SYNC_BYTE) begin
				if (run_len != 4'd15)
					run_len++;
				if (run_len >= cfg_now.sync_min)
					sync_hit = 1'b1;
				if (run_len > cfg_now.long_min && long_cnt != 3'd7)
					long_cnt++;
			end else begin
				run_len = '0;
			end
		end
		if (b.last) begin
			r.half_trk = pres && b.idx[0];
			r.extra_trk = pres && b.idx[6:1] >= 36;
			r.killer = pres && !sync_hit && b.dlen > cfg_now.killer_len;
			r.sync_anom = pres && long_cnt > cfg_now.long_limit;
			r.long_trk = pres && 32'(b.dlen) > zone_len(b.idx) + 32'(cfg_now.margin);
			// density is judged even for absent tracks, but not out of range
			r.dens_anom = in_rng && b.speed > 32'd3;
			// totals saturate at the top of their widths
			if (r.half_trk && half_tot != '1)
				half_tot++;
			if (r.sync_anom && sync_tot != '1)
				sync_tot++;
			if (r.dens_anom && dens_tot != '1)
				dens_tot++;
			r.half_total = half_tot;
			r.sync_total = sync_tot;
			r.dens_total = dens_tot;
			r.conf = 7'd60 + (half_tot != 0 ? 7'd15 : 7'd0) + (sync_tot != 0 ? 7'd10 : 7'd0)
				+ (dens_tot != 0 ? 7'd10 : 7'd0);
			// per-track state starts over on the next track
			run_len = '0;
			sync_hit = 1'b0;
			long_cnt = '0;
		end
	endtask

	// offer one beat, maybe after an idle gap, and book its report once accepted
	task automatic send_beat(input track_beat_t b, input bit typed, input scan_res_t tres);
		int        gap;
		bit        has_rep;
		scan_res_t r;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		disk_start <= b.disk_start;
		track_index <= b.idx;
		track_present <= b.present;
		byte_valid <= b.bvalid;
		data_byte <= b.dbyte;
		declared_length <= b.dlen;
		speed_zone <= b.speed;
		track_last <= b.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		scan_beat(b, has_rep, r);
		if (has_rep)
			report_q.push_back(typed ? tres : r);
	endtask

	// stop offering and wait for every owed report plus the block's latency
	task automatic drain();
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] i, input logic [15:0] v, input int w);
		cfg_index <= i;
		// junk above the register width must be masked off by the block
		cfg_data <= v | (16'($urandom) << w);
		@(posedge clk);
	endtask

	task automatic write_cfg(input scan_cfg_t c);
		cfg_we <= 1'b1;
		put_reg(REG_SYNC_RUN_MIN, 16'(c.sync_min), 4);
		put_reg(REG_LONG_RUN_MIN, 16'(c.long_min), 4);
		put_reg(REG_LONG_SYNC_LIMIT, 16'(c.long_limit), 3);
		put_reg(REG_KILLER_MIN_LENGTH, c.killer_len, 16);
		put_reg(REG_LONG_TRACK_MARGIN, 16'(c.margin), 12);
		cfg_we <= 1'b0;
		cfg_now = c;
	endtask

	// one half-track of random content; dense tracks are short all-sync odd tracks
	task automatic send_track(input bit dense, input bit fresh_disk, output int n);
		track_beat_t b;
		int          ff_left;
		int          k;
		int unsigned pick;
		bit          noisy;
		b = '0;
		ff_left = 0;
		noisy = 1'b0;
		if (dense) begin
			b.idx = 7'($urandom_range(0, 41) * 2 + 1);
			b.present = 1'b1;
			b.dlen = 16'($urandom);
			b.speed = $urandom;
			if (b.speed <= 32'd3)
				b.speed = 32'd4;
			n = $urandom_range(2, 3);
		end else begin
			b.idx = ($urandom_range(99) < 85) ? 7'($urandom_range(0, 83))
				: 7'($urandom_range(84, 127));
			b.present = $urandom_range(99) < 85;
			// lengths cluster on the killer and long-track thresholds
			case ($urandom_range(3))
				0: b.dlen = 16'($urandom);
				1: b.dlen = 16'(cfg_now.killer_len + $urandom_range(0, 2) - 1);
				2: b.dlen = 16'(zone_len(b.idx) + cfg_now.margin + $urandom_range(0, 2) - 1);
				default: b.dlen = 16'($urandom_range(0, 300));
			endcase
			case ($urandom_range(3))
				0: b.speed = $urandom_range(0, 3);
				1: b.speed = 32'd4;
				2: b.speed = $urandom;
				default: b.speed = 32'hFFFF_FFFF;
			endcase
			pick = $urandom_range(99);
			if (pick < 40)
				n = 1;
			else if (pick < 75)
				n = $urandom_range(2, 8);
			else
				n = $urandom_range(9, 40);
			// a few broken tracks hop index and presence every beat
			noisy = $urandom_range(99) < 10;
		end
		for (k = 0; k < n; k++) begin
			if (dense) begin
				b.disk_start = fresh_disk && k == 0;
				b.bvalid = 1'b1;
				b.dbyte = SYNC_BYTE;
			end else begin
				b.disk_start = (fresh_disk && k == 0) || $urandom_range(99) == 0;
				if (noisy) begin
					b.idx = 7'($urandom);
					b.present = 1'($urandom_range(1));
				end
				b.bvalid = $urandom_range(99) < 90;
				if (ff_left == 0 && $urandom_range(1) == 1)
					ff_left = $urandom_range(1, 20);
				if (ff_left != 0) begin
					b.dbyte = SYNC_BYTE;
					ff_left--;
				end else begin
					b.dbyte = 8'($urandom_range(0, 255));
				end
			end
			b.last = k == n - 1;
			send_beat(b, 1'b0, '0);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	function automatic track_beat_t mk_beat(input logic ds, input logic [6:0] idx,
		input logic pres, input logic bv, input logic [7:0] dbyte, input logic [15:0] dlen,
		input logic [31:0] speed, input logic last);
		return {ds, idx, pres, bv, dbyte, dlen, speed, last};
	endfunction

	function automatic scan_res_t mk_rep(input logic [5:0] flags, input logic [5:0] htot,
		input logic [6:0] stot, input logic [6:0] dtot, input logic [6:0] conf);
		return {flags, htot, stot, dtot, conf};
	endfunction

	// result side: check every accepted report, stall at random or on request
	always @(posedge clk) begin : result_check
		scan_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (report_q.size() == 0) begin
				$error("result beat with no report expected");
				err_cnt++;
			end else begin
				want = report_q.pop_front();
				check_field("is_half_track", 32'(want.half_trk), 32'(is_half_track));
				check_field("is_extra_track", 32'(want.extra_trk), 32'(is_extra_track));
				check_field("killer_track", 32'(want.killer), 32'(killer_track));
				check_field("sync_anomaly", 32'(want.sync_anom), 32'(sync_anomaly));
				check_field("long_track", 32'(want.long_trk), 32'(long_track));
				check_field("density_anomaly", 32'(want.dens_anom), 32'(density_anomaly));
				check_field("half_track_total", 32'(want.half_total),
					32'(half_track_total));
				check_field("sync_anomaly_total", 32'(want.sync_total),
					32'(sync_anomaly_total));
				check_field("density_anomaly_total", 32'(want.dens_total),
					32'(density_anomaly_total));
				check_field("confidence", 32'(want.conf), 32'(confidence));
			end
		end
		// a toggle of hold_tgl asks for one long hold-off
		if (hold_tgl != hold_seen) begin
			hold_seen = hold_tgl;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct;
		end
	end

	// stimulus
	initial begin : stimulus
		dir_row_t dir_q[$];
		dir_row_t row;
		int       s;
		int       sent;
		int       n;
		int       target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		disk_start = 1'b0;
		track_index = '0;
		track_present = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		declared_length = '0;
		speed_zone = '0;
		track_last = 1'b0;

		// directed rows at reset register values
		// empty first track right after reset
		dir_q.push_back({mk_beat(1, 0, 1, 0, 8'h00, 0, 0, 1), 1'b1,
			mk_rep(6'b000000, 0, 0, 0, 60)});
		// index past the table: no flags, totals untouched
		dir_q.push_back({mk_beat(0, 127, 1, 1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1), 1'b1,
			mk_rep(6'b000000, 0, 0, 0, 60)});
		// top index, length and speed word at their maximum
		dir_q.push_back({mk_beat(0, 83, 1, 0, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1), 1'b1,
			mk_rep(6'b111011, 1, 0, 1, 85)});
		// absent track: density only
		dir_q.push_back({mk_beat(0, 1, 0, 1, 8'hFF, 16'hFFFF, 32'd4, 1), 1'b1,
			mk_rep(6'b000001, 1, 0, 2, 85)});
		// speed word at 3, length just over the killer threshold
		dir_q.push_back({mk_beat(0, 2, 1, 0, 8'h00, 16'd101, 32'd3, 1), 1'b1,
			mk_rep(6'b001000, 1, 0, 2, 85)});
		// first extra track, length at the killer threshold
		dir_q.push_back({mk_beat(0, 72, 1, 0, 8'h00, 16'd100, 32'd0, 1), 1'b1,
			mk_rep(6'b010000, 1, 0, 2, 85)});
		// long-track edge on both sides of the first zone boundary, at and one over
		dir_q.push_back({mk_beat(0, 35, 1, 0, 8'h00, 16'd7892, 32'd0, 1), 1'b1,
			mk_rep(6'b101000, 2, 0, 2, 85)});
		dir_q.push_back({mk_beat(0, 36, 1, 0, 8'h00, 16'd7343, 32'd0, 1), 1'b1,
			mk_rep(6'b001010, 2, 0, 2, 85)});
		// five sync bytes reach the sync threshold on the last beat
		repeat (4)
			dir_q.push_back({mk_beat(0, 4, 1, 1, 8'hFF, 16'd200, 32'd0, 0), 1'b0,
				scan_res_t'(0)});
		dir_q.push_back({mk_beat(0, 4, 1, 1, 8'hFF, 16'd200, 32'd0, 1), 1'b0,
			scan_res_t'(0)});
		// run state cleared at track end; invalid byte ignored
		dir_q.push_back({mk_beat(0, 5, 1, 0, 8'hFF, 16'hFFFF, 32'd0, 0), 1'b0,
			scan_res_t'(0)});
		dir_q.push_back({mk_beat(0, 5, 1, 1, 8'hFF, 16'hFFFF, 32'd0, 1), 1'b0,
			scan_res_t'(0)});
		// disk start clears totals before counting this track
		dir_q.push_back({mk_beat(1, 9, 1, 1, 8'h00, 16'd0, 32'd0, 1), 1'b1,
			mk_rep(6'b100000, 1, 0, 0, 75)});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_q[i]) begin
			row = dir_q[i];
			send_beat(row.beat, row.typed, row.rep);
		end

		// random segments: idling mode changes every two, registers every one after the first
		for (s = 0; s < 6; s++) begin
			drain();
			case (s / 2)
				0: begin
					send_idle_pct = 16;
					recv_idle_pct <= 45;
				end
				1: begin
					send_idle_pct = 45;
					recv_idle_pct <= 16;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			case (s)
				1, 4: write_cfg(CFG_LOW);
				2: write_cfg(CFG_HIGH);
				3, 5: write_cfg({4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
					3'($urandom_range(0, 7)), 16'($urandom), 12'($urandom)});
				default: ;
			endcase
			// long result hold-off while beats keep coming, so the input backs up
			if (s == 1)
				hold_tgl <= ~hold_tgl;
			// dense segment drives every disk total into saturation
			target = (s == 4) ? 330 : 95;
			sent = 0;
			while (sent < target) begin
				send_track(s == 4, s == 4 && sent == 0, n);
				sent += n;
			end
		end

		drain();
		if (err_cnt == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
